>>> hw/rtl/rri_pkg.sv
// shared widths, register codes and beat structs for the ray rectangle intersect block
package rri_pkg;

    localparam int POS_W     = 21;
    localparam int DIR_W     = 18;
    localparam int AXIS_W    = 18;
    localparam int EXT_W     = 20;
    localparam int DIST_W    = 24;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 120;
    localparam int OUT_W     = 24;

    localparam int DIFF_W  = 22;
    localparam int CROSS_W = 37;
    localparam int NRM_W   = 22;
    localparam int ND_W    = 43;
    localparam int NQ_W    = 47;
    localparam int DA_W    = 38;
    localparam int DD_W    = 42;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 43;
    localparam int QUO_W   = 34;
    localparam int TQ_W    = 35;
    localparam int TD_W    = 53;
    localparam int PC_W    = 37;
    localparam int PS_W    = 56;
    localparam int S_W     = 40;
    localparam int SC_W    = 21;
    localparam int PM_W    = 59;
    localparam int ACC_W   = 62;
    localparam int T_W     = 30;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [QUO_W-1:0] T_LIMIT = 34'h2_0000_0000;
    localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7F_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh80_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_AXIS_H   = 3'd1,
        CFG_AXIS_V   = 3'd2,
        CFG_EXTENT_H = 3'd3,
        CFG_EXTENT_V = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [3*POS_W-1:0]  center;
        logic [3*AXIS_W-1:0] axis_h;
        logic [3*AXIS_W-1:0] axis_v;
        logic [EXT_W-1:0]    ext_h;
        logic [EXT_W-1:0]    ext_v;
    } cfg_t;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] diff;
        logic [2:0][DIR_W-1:0]  d;
        logic [ND_W-1:0]        nd;
        logic [NQ_W-1:0]        nq;
        logic [DA_W-1:0]        dh;
        logic [DA_W-1:0]        dv;
        logic [DD_W-1:0]        dd;
        logic                   par;
    } front_item_t;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] diff;
        logic [2:0][DIR_W-1:0]  d;
        logic [DA_W-1:0]        dh;
        logic [DA_W-1:0]        dv;
        logic [DD_W-1:0]        dd;
        logic                   par;
        logic                   neg;
    } back_side_t;

endpackage

>>> hw/rtl/ray_rectangle_intersect.sv
// top level: config registers, front pipeline, queue and back pipeline
// throughput: one ray per cycle unless m_tready or a full queue stalls it; the divider has 34 stages, one bit per stage
// config changes reach the plane normal through cfg_reg, cross_reg and nrm_reg in turn
// reset: async active-low, clears config registers, valid bits and queue pointers and count
module ray_rectangle_intersect
#(
    parameter int QUEUE_DEPTH = rri_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rri_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rri_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [rri_pkg::IN_W-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // distance_t
    output logic [rri_pkg::OUT_W-1:0]      m_tdata,
    // hit
    output logic [0:0]                     m_tuser
);
    import rri_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        q_push, q_pop, q_full, q_empty;
    front_item_t q_wr_item, q_rd_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER:   cfg_next.center = cfg_data;
                CFG_AXIS_H:   cfg_next.axis_h = cfg_data[3*AXIS_W-1:0];
                CFG_AXIS_V:   cfg_next.axis_v = cfg_data[3*AXIS_W-1:0];
                CFG_EXTENT_H: cfg_next.ext_h  = cfg_data[EXT_W-1:0];
                CFG_EXTENT_V: cfg_next.ext_v  = cfg_data[EXT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rri_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_wr_item)
    );

    rri_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    rri_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hw/rtl/rri_front.sv
// front pipeline: accepts rays, forms plane normal products and flags parallel rays
module rri_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rri_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rri_pkg::IN_W-1:0]  in_data,
    input  logic                      q_full,
    output logic                      q_push,
    output rri_pkg::front_item_t      q_item
);
    import rri_pkg::*;

    logic adv;

    logic signed [AXIS_W-1:0]  ah [3];
    logic signed [AXIS_W-1:0]  av [3];
    logic signed [POS_W-1:0]   cc [3];
    logic signed [CROSS_W-1:0] cross_reg [3];
    logic signed [CROSS_W-1:0] cross_next [3];
    logic signed [NRM_W-1:0]   nrm_reg [3];
    logic signed [NRM_W-1:0]   nrm_next [3];

    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [POS_W-1:0]   o0_reg [3];
    logic signed [POS_W-1:0]   o0_next [3];
    logic signed [DIR_W-1:0]   d0_reg [3];
    logic signed [DIR_W-1:0]   d0_next [3];
    logic signed [DIFF_W-1:0]  diff1_reg [3];
    logic signed [DIFF_W-1:0]  diff1_next [3];
    logic signed [DIR_W-1:0]   d1_reg [3];
    logic signed [DIFF_W-1:0]  diff2_reg [3];
    logic signed [DIR_W-1:0]   d2_reg [3];
    logic signed [ND_W-1:0]    pnd_reg [3];
    logic signed [ND_W-1:0]    pnd_next [3];
    logic signed [NQ_W-1:0]    pnq_reg [3];
    logic signed [NQ_W-1:0]    pnq_next [3];
    logic signed [DA_W-1:0]    pdh_reg [3];
    logic signed [DA_W-1:0]    pdh_next [3];
    logic signed [DA_W-1:0]    pdv_reg [3];
    logic signed [DA_W-1:0]    pdv_next [3];
    logic signed [DD_W-1:0]    pdd_reg [3];
    logic signed [DD_W-1:0]    pdd_next [3];
    front_item_t               item_reg;
    front_item_t               item_next;
    logic signed [ND_W-1:0]    nd_sum;

    assign adv      = !q_full;
    assign in_ready = adv;
    assign q_push   = v3_reg && adv;
    assign q_item   = item_reg;

    // plane normal from the axes, refreshed every cycle
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ah[i] = $signed(cfg.axis_h[AXIS_W*i +: AXIS_W]);
            av[i] = $signed(cfg.axis_v[AXIS_W*i +: AXIS_W]);
            cc[i] = $signed(cfg.center[POS_W*i +: POS_W]);
        end
        cross_next[0] = CROSS_W'(ah[1]) * CROSS_W'(av[2]) - CROSS_W'(ah[2]) * CROSS_W'(av[1]);
        cross_next[1] = CROSS_W'(ah[2]) * CROSS_W'(av[0]) - CROSS_W'(ah[0]) * CROSS_W'(av[2]);
        cross_next[2] = CROSS_W'(ah[0]) * CROSS_W'(av[1]) - CROSS_W'(ah[1]) * CROSS_W'(av[0]);
        for (int i = 0; i < 3; i++)
        begin
            nrm_next[i] = NRM_W'((cross_reg[i] + CROSS_W'(32'sd32768)) >>> 16);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o0_next[i]    = $signed(in_data[POS_W*i +: POS_W]);
            d0_next[i]    = $signed(in_data[3*POS_W + DIR_W*i +: DIR_W]);
            diff1_next[i] = DIFF_W'(o0_reg[i]) - DIFF_W'(cc[i]);
            pnd_next[i]   = ND_W'(nrm_reg[i]) * ND_W'(d1_reg[i]);
            pnq_next[i]   = NQ_W'(nrm_reg[i]) * NQ_W'(diff1_reg[i]);
            pdh_next[i]   = DA_W'(d1_reg[i]) * DA_W'(ah[i]);
            pdv_next[i]   = DA_W'(d1_reg[i]) * DA_W'(av[i]);
            pdd_next[i]   = DD_W'(d1_reg[i]) * DD_W'(diff1_reg[i]);
        end
    end

    always_comb
    begin
        nd_sum = pnd_reg[0] + pnd_reg[1] + pnd_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            item_next.diff[i] = diff2_reg[i];
            item_next.d[i]    = d2_reg[i];
        end
        item_next.nd  = nd_sum;
        item_next.nq  = pnq_reg[0] + pnq_reg[1] + pnq_reg[2];
        item_next.dh  = pdh_reg[0] + pdh_reg[1] + pdh_reg[2];
        item_next.dv  = pdv_reg[0] + pdv_reg[1] + pdv_reg[2];
        item_next.dd  = pdd_reg[0] + pdd_reg[1] + pdd_reg[2];
        item_next.par = (nd_sum == '0);
    end

    always_ff @(posedge clk)
    begin
        cross_reg <= cross_next;
        nrm_reg   <= nrm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o0_reg    <= o0_next;
            d0_reg    <= d0_next;
            diff1_reg <= diff1_next;
            d1_reg    <= d0_reg;
            diff2_reg <= diff1_reg;
            d2_reg    <= d1_reg;
            pnd_reg   <= pnd_next;
            pnq_reg   <= pnq_next;
            pdh_reg   <= pdh_next;
            pdv_reg   <= pdv_next;
            pdd_reg   <= pdd_next;
            item_reg  <= item_next;
        end
    end

endmodule

>>> hw/rtl/rri_queue.sv
// short queue between the front and back pipelines
module rri_queue
#(
    parameter int DEPTH = rri_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  rri_pkg::front_item_t wr_item,
    output logic                 full,
    input  logic                 rd_en,
    output rri_pkg::front_item_t rd_item,
    output logic                 empty
);
    import rri_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    front_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

>>> hw/rtl/rri_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module rri_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rri_pkg::NUM_W-1:0]   in_num,
    input  logic [rri_pkg::DEN_W-1:0]   in_den,
    input  rri_pkg::back_side_t         in_side,
    output logic                        out_valid,
    output logic [rri_pkg::QUO_W-1:0]   out_quo,
    output logic                        out_ovf,
    output rri_pkg::back_side_t         out_side
);
    import rri_pkg::*;

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] rem_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0] low_reg   [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic             ovf_reg   [QUO_W];
    back_side_t       side_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic             ovf_in;
        back_side_t       side_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign den_in  = in_den;
            assign low_in  = in_num[QUO_W-1:0];
            assign quo_in  = '0;
            assign ovf_in  = (DEN_W'(in_num[NUM_W-1:QUO_W]) >= in_den);
            assign side_in = in_side;
        end
        else
        begin : g_body
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial    = {rem_in, low_in[QUO_W-1-k]};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        assign quo_next = {quo_in[QUO_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                low_reg[k]  <= low_in;
                quo_reg[k]  <= quo_next;
                ovf_reg[k]  <= ovf_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_ovf   = ovf_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

>>> hw/rtl/rri_back.sv
// back pipeline: ray parameter, hit point, extent test and distance
module rri_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rri_pkg::cfg_t              cfg,
    input  logic                       q_empty,
    input  rri_pkg::front_item_t       q_item,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rri_pkg::OUT_W-1:0]  m_tdata,
    output logic [0:0]                 m_tuser
);
    import rri_pkg::*;

    logic adv;

    // queue head decode
    logic signed [NQ_W-1:0] nq_s;
    logic signed [ND_W-1:0] nd_s;
    logic [NQ_W-1:0]        nq_mag;
    logic [ND_W-1:0]        nd_mag;
    logic                   b0_valid_reg;
    logic [NUM_W-1:0]       b0_num_reg, b0_num_next;
    logic [DEN_W-1:0]       b0_den_reg, b0_den_next;
    back_side_t             b0_side_reg, b0_side_next;

    logic                   dv_valid;
    logic [QUO_W-1:0]       dv_quo;
    logic                   dv_ovf;
    back_side_t             dv_side;

    logic [QUO_W-1:0]       tq_mag;
    logic                   b1_valid_reg;
    logic signed [TQ_W-1:0] b1_tq_reg, b1_tq_next;
    back_side_t             b1_side_reg;

    logic                   b2_valid_reg;
    logic signed [TD_W-1:0] b2_td_reg [3];
    logic signed [TD_W-1:0] b2_td_next [3];
    back_side_t             b2_side_reg;

    logic                   b3_valid_reg;
    logic signed [PC_W-1:0] b3_pc_reg [3];
    logic signed [PC_W-1:0] b3_pc_next [3];
    back_side_t             b3_side_reg;

    logic signed [AXIS_W-1:0] ah [3];
    logic signed [AXIS_W-1:0] av [3];
    logic                   b4_valid_reg;
    logic signed [PS_W-1:0] b4_ph_reg [3];
    logic signed [PS_W-1:0] b4_ph_next [3];
    logic signed [PS_W-1:0] b4_pv_reg [3];
    logic signed [PS_W-1:0] b4_pv_next [3];
    back_side_t             b4_side_reg;

    logic                   b5_valid_reg;
    logic signed [S_W-1:0]  b5_s0_reg, b5_s0_next;
    logic signed [S_W-1:0]  b5_s1_reg, b5_s1_next;
    back_side_t             b5_side_reg;

    logic [S_W-1:0]         s0_mag, s1_mag;
    logic                   b6_valid_reg;
    logic                   b6_hit_reg, b6_hit_next;
    logic signed [SC_W-1:0] b6_s0_reg, b6_s1_reg;
    back_side_t             b6_side_reg;

    logic                   b7_valid_reg;
    logic                   b7_hit_reg;
    logic signed [PM_W-1:0] b7_p0_reg, b7_p0_next;
    logic signed [PM_W-1:0] b7_p1_reg, b7_p1_next;
    logic signed [ACC_W-1:0] b7_dd_reg, b7_dd_next;

    logic signed [ACC_W-1:0] acc;
    logic signed [T_W-1:0]   t_full;
    logic signed [DIST_W-1:0] t_sat;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [DIST_W-1:0]      out_dist_reg, out_dist_next;

    assign adv      = !out_valid_reg || m_tready;
    assign q_pop    = adv && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_hit_reg;

    always_comb
    begin
        nq_s   = $signed(q_item.nq);
        nd_s   = $signed(q_item.nd);
        nq_mag = nq_s[NQ_W-1] ? NQ_W'(-nq_s) : NQ_W'(nq_s);
        nd_mag = nd_s[ND_W-1] ? ND_W'(-nd_s) : ND_W'(nd_s);
        // rounded magnitude division: numerator carries half the divisor
        b0_num_next = (NUM_W'(nq_mag) << 16) + NUM_W'(nd_mag >> 1);
        b0_den_next = DEN_W'(nd_mag);
        b0_side_next.diff = q_item.diff;
        b0_side_next.d    = q_item.d;
        b0_side_next.dh   = q_item.dh;
        b0_side_next.dv   = q_item.dv;
        b0_side_next.dd   = q_item.dd;
        b0_side_next.par  = q_item.par;
        b0_side_next.neg  = (nq_s > 0) != nd_s[ND_W-1];
    end

    rri_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b0_valid_reg),
        .in_num    (b0_num_reg),
        .in_den    (b0_den_reg),
        .in_side   (b0_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side)
    );

    always_comb
    begin
        tq_mag     = (dv_ovf || (dv_quo > T_LIMIT)) ? T_LIMIT : dv_quo;
        b1_tq_next = dv_side.neg ? -$signed(TQ_W'(tq_mag)) : $signed(TQ_W'(tq_mag));
        for (int i = 0; i < 3; i++)
        begin
            ah[i]         = $signed(cfg.axis_h[AXIS_W*i +: AXIS_W]);
            av[i]         = $signed(cfg.axis_v[AXIS_W*i +: AXIS_W]);
            b2_td_next[i] = TD_W'(b1_tq_reg) * TD_W'($signed(b1_side_reg.d[i]));
            b3_pc_next[i] = PC_W'($signed(b2_side_reg.diff[i]))
                          + PC_W'((b2_td_reg[i] + TD_W'(32'sd32768)) >>> 16);
            b4_ph_next[i] = PS_W'(ah[i]) * PS_W'(b3_pc_reg[i]);
            b4_pv_next[i] = PS_W'(av[i]) * PS_W'(b3_pc_reg[i]);
        end
        b5_s0_next = S_W'((b4_ph_reg[0] + b4_ph_reg[1] + b4_ph_reg[2] + PS_W'(32'sd32768)) >>> 16);
        b5_s1_next = S_W'((b4_pv_reg[0] + b4_pv_reg[1] + b4_pv_reg[2] + PS_W'(32'sd32768)) >>> 16);
    end

    always_comb
    begin
        s0_mag      = b5_s0_reg[S_W-1] ? S_W'(-b5_s0_reg) : S_W'(b5_s0_reg);
        s1_mag      = b5_s1_reg[S_W-1] ? S_W'(-b5_s1_reg) : S_W'(b5_s1_reg);
        b6_hit_next = !b5_side_reg.par && (s0_mag <= S_W'(cfg.ext_h))
                      && (s1_mag <= S_W'(cfg.ext_v));
        b7_p0_next  = PM_W'(b6_s0_reg) * PM_W'($signed(b6_side_reg.dh));
        b7_p1_next  = PM_W'(b6_s1_reg) * PM_W'($signed(b6_side_reg.dv));
        b7_dd_next  = ACC_W'($signed(b6_side_reg.dd)) <<< 16;
    end

    always_comb
    begin
        acc    = ACC_W'(b7_p0_reg) + ACC_W'(b7_p1_reg) - b7_dd_reg;
        t_full = T_W'((acc + ACC_W'(64'sd2147483648)) >>> 32);
        if (t_full > T_W'(DIST_MAX))
        begin
            t_sat = DIST_MAX;
        end
        else if (t_full < T_W'(DIST_MIN))
        begin
            t_sat = DIST_MIN;
        end
        else
        begin
            t_sat = DIST_W'(t_full);
        end
        out_dist_next = b7_hit_reg ? t_sat : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            b6_valid_reg  <= 1'b0;
            b7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg  <= !q_empty;
            b1_valid_reg  <= dv_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            b6_valid_reg  <= b5_valid_reg;
            b7_valid_reg  <= b6_valid_reg;
            out_valid_reg <= b7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_num_reg   <= b0_num_next;
            b0_den_reg   <= b0_den_next;
            b0_side_reg  <= b0_side_next;
            b1_tq_reg    <= b1_tq_next;
            b1_side_reg  <= dv_side;
            b2_td_reg    <= b2_td_next;
            b2_side_reg  <= b1_side_reg;
            b3_pc_reg    <= b3_pc_next;
            b3_side_reg  <= b2_side_reg;
            b4_ph_reg    <= b4_ph_next;
            b4_pv_reg    <= b4_pv_next;
            b4_side_reg  <= b3_side_reg;
            b5_s0_reg    <= b5_s0_next;
            b5_s1_reg    <= b5_s1_next;
            b5_side_reg  <= b4_side_reg;
            b6_hit_reg   <= b6_hit_next;
            b6_s0_reg    <= SC_W'(b5_s0_reg);
            b6_s1_reg    <= SC_W'(b5_s1_reg);
            b6_side_reg  <= b5_side_reg;
            b7_hit_reg   <= b6_hit_reg;
            b7_p0_reg    <= b7_p0_next;
            b7_p1_reg    <= b7_p1_next;
            b7_dd_reg    <= b7_dd_next;
            out_hit_reg  <= b7_hit_reg;
            out_dist_reg <= out_dist_next;
        end
    end

endmodule
